// ===== hdl/isoep_pkg.sv =====
// ----------------------------------------------------------------------------
// isoep_pkg
// shared types, constants and helper functions for the timestamp text decoder
// ----------------------------------------------------------------------------
package isoep_pkg;

    localparam int DIGIT_LIMIT   = 9;
    localparam int DIGIT_CNT_W   = 4;
    localparam int ACCUM_W       = 30;
    localparam int FIELD_W       = 31;
    localparam int FIELD_IDX_W   = 3;
    localparam int STORE_DEPTH   = 5;
    localparam int EPOCH_W       = 57;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = 3'd5;
    localparam logic [FIELD_IDX_W-1:0] FLD_YEAR   = 3'd0;
    localparam logic [FIELD_IDX_W-1:0] FLD_MONTH  = 3'd1;
    localparam logic [FIELD_IDX_W-1:0] FLD_DAY    = 3'd2;
    localparam logic [FIELD_IDX_W-1:0] FLD_HOUR   = 3'd3;
    localparam logic [FIELD_IDX_W-1:0] FLD_MINUTE = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_T     = 8'h54;

    // floor division of the shifted year by 400 through a reciprocal of 25
    localparam int          ERA_BIAS_LOG = 22;
    localparam logic [31:0] YEAR_OFFSET  = 32'(400 * (2 ** ERA_BIAS_LOG));
    localparam int          RECIP_SHIFT  = 32;
    localparam logic [27:0] RECIP_25     = 28'd171798692;
    localparam logic [24:0] ERA_BIAS     = 25'(2 ** ERA_BIAS_LOG);

    localparam logic signed [42:0] DAYS_PER_ERA   = 43'sd146097;
    localparam logic signed [43:0] EPOCH_DAY_SHIFT = 44'sd719468;
    localparam logic signed [52:0] DAY_SCALE      = 53'sd675;
    localparam int                 DAY_SCALE_SH   = 7;
    localparam logic signed [43:0] SEC_PER_HOUR   = 44'sd3600;
    localparam logic signed [43:0] SEC_PER_MIN    = 44'sd60;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } scan_phase_t;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_QUOT,
        CV_YOE,
        CV_DOE,
        CV_DAYS,
        CV_SCALE,
        CV_SUM
    } conv_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic signed [EPOCH_W-1:0] epoch_seconds;
        logic                      valid_res;
    } epoch_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] year;
        logic [3:0]                month;
        logic [4:0]                day;
        logic signed [FIELD_W-1:0] hour;
        logic signed [FIELD_W-1:0] minute;
        logic signed [FIELD_W-1:0] second;
        logic                      ok;
    } conv_job_t;

    function automatic logic [7:0] sep_char(input logic [FIELD_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            FLD_YEAR, FLD_MONTH: c = CH_MINUS;
            FLD_DAY:             c = CH_T;
            default:             c = CH_COLON;
        endcase
        return c;
    endfunction

    // days before the month in a year starting in march
    function automatic logic [8:0] doy_offset(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/isoep_scan.sv =====
// ----------------------------------------------------------------------------
// isoep_scan
// character scanner: parses six signed numbers and closes a request per text
// ----------------------------------------------------------------------------
module isoep_scan
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  isoep_pkg::char_item_t  item,
    output isoep_pkg::conv_job_t   job
);

    logic [isoep_pkg::FIELD_IDX_W-1:0] fnum_reg, fnum_next;
    isoep_pkg::scan_phase_t            phase_reg, phase_next;
    logic [isoep_pkg::ACCUM_W-1:0]     accum_reg, accum_next;
    logic [isoep_pkg::DIGIT_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                              neg_reg, neg_next;
    logic                              fin_reg, fin_next;
    logic                              fail_reg, fail_next;
    logic signed [isoep_pkg::FIELD_W-1:0] store_reg [isoep_pkg::STORE_DEPTH];
    logic                              store_we;

    logic [7:0] c;
    logic       is_digit;
    logic [3:0] digit_val;
    logic signed [isoep_pkg::FIELD_W-1:0] cur_value;

    logic                    end_fail;
    isoep_pkg::scan_phase_t  end_phase;
    logic signed [isoep_pkg::FIELD_W-1:0] mon_val;
    logic signed [isoep_pkg::FIELD_W-1:0] day_val;

    assign c         = item.char_code;
    assign is_digit  = c inside {[isoep_pkg::CH_ZERO:isoep_pkg::CH_NINE]};
    assign digit_val = 4'(c - isoep_pkg::CH_ZERO);

    always_comb
    begin
        fnum_next  = fnum_reg;
        phase_next = phase_reg;
        accum_next = accum_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        fin_next   = fin_reg;
        fail_next  = fail_reg;
        store_we   = 1'b0;
        if (!fin_reg && !fail_reg)
        begin
            if (c == isoep_pkg::CH_NUL)
            begin
                if (phase_reg == isoep_pkg::PH_DIGITS && fnum_reg == isoep_pkg::LAST_FIELD)
                    phase_next = isoep_pkg::PH_DONE;
                else
                    fail_next = 1'b1;
                fin_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    isoep_pkg::PH_START:
                    begin
                        if (c inside {isoep_pkg::CH_SPACE, [isoep_pkg::CH_TAB:isoep_pkg::CH_CR]})
                        begin
                            phase_next = isoep_pkg::PH_START;
                        end
                        else if (c inside {isoep_pkg::CH_PLUS, isoep_pkg::CH_MINUS})
                        begin
                            neg_next   = (c == isoep_pkg::CH_MINUS);
                            phase_next = isoep_pkg::PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            accum_next = isoep_pkg::ACCUM_W'(digit_val);
                            dcnt_next  = isoep_pkg::DIGIT_CNT_W'(1);
                            phase_next = isoep_pkg::PH_DIGITS;
                        end
                        else
                            fail_next = 1'b1;
                    end
                    isoep_pkg::PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            accum_next = isoep_pkg::ACCUM_W'(digit_val);
                            dcnt_next  = isoep_pkg::DIGIT_CNT_W'(1);
                            phase_next = isoep_pkg::PH_DIGITS;
                        end
                        else
                            fail_next = 1'b1;
                    end
                    isoep_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            if (dcnt_reg >= isoep_pkg::DIGIT_CNT_W'(isoep_pkg::DIGIT_LIMIT))
                                fail_next = 1'b1;
                            else
                            begin
                                accum_next = (accum_reg << 3) + (accum_reg << 1)
                                           + isoep_pkg::ACCUM_W'(digit_val);
                                dcnt_next  = dcnt_reg + isoep_pkg::DIGIT_CNT_W'(1);
                            end
                        end
                        else if (fnum_reg >= isoep_pkg::LAST_FIELD)
                        begin
                            phase_next = isoep_pkg::PH_DONE;
                            fin_next   = 1'b1;
                        end
                        else if (c != isoep_pkg::sep_char(fnum_reg))
                            fail_next = 1'b1;
                        else
                        begin
                            store_we   = 1'b1;
                            fnum_next  = fnum_reg + isoep_pkg::FIELD_IDX_W'(1);
                            phase_next = isoep_pkg::PH_START;
                            accum_next = '0;
                            dcnt_next  = '0;
                            neg_next   = 1'b0;
                        end
                    end
                    default:
                        fin_next = 1'b1;
                endcase
            end
        end
    end

    assign cur_value = neg_reg ? -$signed({1'b0, accum_reg}) : $signed({1'b0, accum_reg});

    // text end on the marked character
    always_comb
    begin
        end_phase = phase_next;
        end_fail  = fail_next;
        if (!fin_next && !fail_next)
        begin
            if (phase_next == isoep_pkg::PH_DIGITS && fnum_next == isoep_pkg::LAST_FIELD)
                end_phase = isoep_pkg::PH_DONE;
            else
                end_fail = 1'b1;
        end
    end

    assign mon_val = store_reg[isoep_pkg::FLD_MONTH];
    assign day_val = store_reg[isoep_pkg::FLD_DAY];

    always_comb
    begin
        job.year   = store_reg[isoep_pkg::FLD_YEAR];
        job.month  = mon_val[3:0];
        job.day    = day_val[4:0];
        job.hour   = store_reg[isoep_pkg::FLD_HOUR];
        job.minute = store_reg[isoep_pkg::FLD_MINUTE];
        job.second = neg_next ? -$signed({1'b0, accum_next}) : $signed({1'b0, accum_next});
        job.ok     = !end_fail && end_phase == isoep_pkg::PH_DONE
                   && mon_val >= 31'sd1 && mon_val <= 31'sd12
                   && day_val >= 31'sd1 && day_val <= 31'sd31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnum_reg  <= '0;
            phase_reg <= isoep_pkg::PH_START;
            accum_reg <= '0;
            dcnt_reg  <= '0;
            neg_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            for (int i = 0; i < isoep_pkg::STORE_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else if (take)
        begin
            if (item.last_char)
            begin
                fnum_reg  <= '0;
                phase_reg <= isoep_pkg::PH_START;
                accum_reg <= '0;
                dcnt_reg  <= '0;
                neg_reg   <= 1'b0;
                fin_reg   <= 1'b0;
                fail_reg  <= 1'b0;
                for (int i = 0; i < isoep_pkg::STORE_DEPTH; i++)
                    store_reg[i] <= '0;
            end
            else
            begin
                fnum_reg  <= fnum_next;
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                dcnt_reg  <= dcnt_next;
                neg_reg   <= neg_next;
                fin_reg   <= fin_next;
                fail_reg  <= fail_next;
                if (store_we)
                    store_reg[fnum_reg] <= cur_value;
            end
        end
    end

endmodule

// ===== hdl/isoep_queue.sv =====
// ----------------------------------------------------------------------------
// isoep_queue
// two-entry queue of parsed requests between scanner and converter
// ----------------------------------------------------------------------------
module isoep_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  isoep_pkg::conv_job_t  push_job,
    output logic                  not_full,
    input  logic                  pop,
    output logic                  not_empty,
    output isoep_pkg::conv_job_t  head_job
);

    isoep_pkg::conv_job_t               slot_reg [isoep_pkg::QUEUE_DEPTH];
    logic [isoep_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [isoep_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [isoep_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign not_full  = count_reg != isoep_pkg::QUEUE_CNT_W'(isoep_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + isoep_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + isoep_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + isoep_pkg::QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - isoep_pkg::QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hdl/isoep_conv.sv =====
// ----------------------------------------------------------------------------
// isoep_conv
// civil date to epoch seconds converter, one request at a time
// ----------------------------------------------------------------------------
module isoep_conv
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  isoep_pkg::conv_job_t  job,
    output logic                  job_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output isoep_pkg::epoch_item_t res
);

    isoep_pkg::conv_state_t state_reg, state_next;

    isoep_pkg::conv_job_t         job_reg;
    logic [31:0]                  t_reg;
    logic [55:0]                  prod_reg;
    logic signed [43:0]           h3600_reg;
    logic signed [24:0]           era_reg;
    logic [8:0]                   yoe_reg;
    logic signed [43:0]           hms_reg;
    logic [17:0]                  doe_reg;
    logic signed [42:0]           eraprod_reg;
    logic signed [43:0]           days_reg;
    logic signed [52:0]           scaled_reg;
    logic                         res_valid_reg;
    isoep_pkg::epoch_item_t       res_reg;

    logic                         load_job;
    logic                         out_load;
    logic                         out_free;

    logic signed [31:0]           yy;
    logic [31:0]                  t_val;
    logic [23:0]                  quot;
    logic [31:0]                  yoe_full;
    logic [3:0]                   mp;
    logic [1:0]                   cent;
    logic [17:0]                  doe_val;
    logic signed [56:0]           secs;

    assign out_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isoep_pkg::CV_IDLE:
                if (job_valid)
                    state_next = job.ok ? isoep_pkg::CV_QUOT : isoep_pkg::CV_SUM;
            isoep_pkg::CV_QUOT:  state_next = isoep_pkg::CV_YOE;
            isoep_pkg::CV_YOE:   state_next = isoep_pkg::CV_DOE;
            isoep_pkg::CV_DOE:   state_next = isoep_pkg::CV_DAYS;
            isoep_pkg::CV_DAYS:  state_next = isoep_pkg::CV_SCALE;
            isoep_pkg::CV_SCALE: state_next = isoep_pkg::CV_SUM;
            isoep_pkg::CV_SUM:
                if (out_free)
                    state_next = isoep_pkg::CV_IDLE;
            default: state_next = isoep_pkg::CV_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        load_job  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            isoep_pkg::CV_IDLE:
            begin
                job_ready = 1'b1;
                load_job  = job_valid;
            end
            isoep_pkg::CV_SUM:
                out_load = out_free;
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    // year shifted to a march start, biased positive for the floor division
    assign yy    = 32'(job_reg.year) - ((job_reg.month <= 4'd2) ? 32'sd1 : 32'sd0);
    assign t_val = 32'(yy) + isoep_pkg::YEAR_OFFSET;

    assign quot     = prod_reg[isoep_pkg::RECIP_SHIFT +: 24];
    assign yoe_full = t_reg - (32'(quot) << 8) - (32'(quot) << 7) - (32'(quot) << 4);

    assign mp   = (job_reg.month > 4'd2) ? job_reg.month - 4'd3 : job_reg.month + 4'd9;
    assign cent = 2'(yoe_reg >= 9'd100) + 2'(yoe_reg >= 9'd200) + 2'(yoe_reg >= 9'd300);
    assign doe_val = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) - 18'(cent)
                   + 18'(isoep_pkg::doy_offset(mp)) + 18'(job_reg.day) - 18'd1;

    assign secs = (57'(scaled_reg) <<< isoep_pkg::DAY_SCALE_SH) + 57'(hms_reg);

    always_ff @(posedge clk)
    begin
        if (load_job)
            job_reg <= job;
        case (state_reg)
            isoep_pkg::CV_QUOT:
            begin
                t_reg     <= t_val;
                prod_reg  <= 56'(t_val[31:4]) * 56'(isoep_pkg::RECIP_25);
                h3600_reg <= 44'(job_reg.hour) * isoep_pkg::SEC_PER_HOUR;
            end
            isoep_pkg::CV_YOE:
            begin
                era_reg <= $signed({1'b0, quot}) - $signed(isoep_pkg::ERA_BIAS);
                yoe_reg <= yoe_full[8:0];
                hms_reg <= h3600_reg + 44'(job_reg.minute) * isoep_pkg::SEC_PER_MIN
                         + 44'(job_reg.second);
            end
            isoep_pkg::CV_DOE:
            begin
                doe_reg     <= doe_val;
                eraprod_reg <= 43'(era_reg) * isoep_pkg::DAYS_PER_ERA;
            end
            isoep_pkg::CV_DAYS:
                days_reg <= 44'(eraprod_reg) + $signed({26'b0, doe_reg})
                          - isoep_pkg::EPOCH_DAY_SHIFT;
            isoep_pkg::CV_SCALE:
                scaled_reg <= 53'(days_reg) * isoep_pkg::DAY_SCALE;
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            res_reg.epoch_seconds <= job_reg.ok ? secs : '0;
            res_reg.valid_res     <= job_reg.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isoep_pkg::CV_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/iso8601_text_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// iso8601_text_to_epoch_seconds
// timestamp text in, one character a cycle when ready; epoch seconds per text
// ----------------------------------------------------------------------------
// throughput: one character per cycle while the queue has room; the converter
//   takes one text at a time, with a two-request queue in front; a rejected
//   text skips the arithmetic states and goes from idle to the result state
// reset: rst_n asynchronous, clears scanner, queue and converter control
// ----------------------------------------------------------------------------
module iso8601_text_to_epoch_seconds
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  isoep_pkg::char_item_t  req,
    output logic                   res_valid,
    input  logic                   res_ready,
    output isoep_pkg::epoch_item_t res
);

    logic                 take;
    logic                 q_not_full;
    logic                 q_not_empty;
    logic                 conv_ready;
    isoep_pkg::conv_job_t scan_job;
    isoep_pkg::conv_job_t head_job;

    assign req_ready = q_not_full;
    assign take      = req_valid && req_ready;

    isoep_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (req),
        .job   (scan_job)
    );

    isoep_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && req.last_char),
        .push_job  (scan_job),
        .not_full  (q_not_full),
        .pop       (conv_ready),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    isoep_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .job_ready (conv_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
